// ----- sv/sdsel_pkg.sv -----
// Shared constants and types for the shadow cascade selector.
package sdsel_pkg;

   localparam int MaxCascades = 4;
   localparam int DepthBits   = 24;
   localparam int RegBits     = DepthBits - 1;
   localparam int IdxBits     = 2;
   localparam int CountBits   = 3;
   localparam int FracBits    = 16;
   localparam int WeightBits  = FracBits + 1;
   localparam int CsrIdxBits  = 3;

   localparam logic [CsrIdxBits-1:0] CSR_CASCADE_COUNT = 3'd0;
   localparam logic [CsrIdxBits-1:0] CSR_SPLIT_FAR_0   = 3'd1;
   localparam logic [CsrIdxBits-1:0] CSR_SPLIT_FAR_1   = 3'd2;
   localparam logic [CsrIdxBits-1:0] CSR_SPLIT_FAR_2   = 3'd3;
   localparam logic [CsrIdxBits-1:0] CSR_SPLIT_FAR_3   = 3'd4;
   localparam logic [CsrIdxBits-1:0] CSR_BLEND_START_0 = 3'd5;
   localparam logic [CsrIdxBits-1:0] CSR_BLEND_START_1 = 3'd6;
   localparam logic [CsrIdxBits-1:0] CSR_BLEND_START_2 = 3'd7;

   typedef struct packed {
      logic [CountBits-1:0]                     count;
      logic [MaxCascades-1:0][RegBits-1:0]      far;
      logic [MaxCascades-2:0][RegBits-1:0]      blend;
   } sdsel_cfg_type;

   typedef struct packed {
      logic [IdxBits-1:0] primary;
      logic [IdxBits-1:0] secondary;
      logic               beyond;
      logic               sat;
   } sdsel_side_type;

   typedef struct packed {
      logic [RegBits-1:0]  rem;
      logic [RegBits-1:0]  den;
      logic [FracBits-1:0] quo;
   } sdsel_div_type;

endpackage

// ----- sv/shadow_cascade_selector_core.sv -----
// Shadow cascade selector top level: CSR bank, select stages and divider cell chain.
// One depth per clock is taken whenever busy is low; busy is high only during reset.
// Each transaction yields one result: rsp_strobe marks it once the transaction has
// passed 18 register stages: two select stages followed by a chain of 16 divider
// cells, one weight bit per cell. The result cannot be held off. CSR writes apply
// to transactions started after the write and to one in its second select stage;
// change them only while no transaction is in flight.
module shadow_cascade_selector_core import sdsel_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [DepthBits-1:0] req_view_depth,
   output logic                        rsp_strobe,
   output logic [IdxBits-1:0]          rsp_primary_cascade,
   output logic [IdxBits-1:0]          rsp_secondary_cascade,
   output logic [WeightBits-1:0]       rsp_secondary_weight,
   output logic                        rsp_beyond_range,
   input  logic                        csr_write_enable,
   input  logic [CsrIdxBits-1:0]       csr_index,
   input  logic [RegBits-1:0]          csr_write_data
);

   sdsel_cfg_type  cfg_ff, cfg_in;
   logic           accept;

   logic           chain_valid [FracBits+1];
   sdsel_side_type chain_side  [FracBits+1];
   sdsel_div_type  chain_div   [FracBits+1];

   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CASCADE_COUNT: cfg_in.count    = csr_write_data[CountBits-1:0];
            CSR_SPLIT_FAR_0:   cfg_in.far[0]   = csr_write_data;
            CSR_SPLIT_FAR_1:   cfg_in.far[1]   = csr_write_data;
            CSR_SPLIT_FAR_2:   cfg_in.far[2]   = csr_write_data;
            CSR_SPLIT_FAR_3:   cfg_in.far[3]   = csr_write_data;
            CSR_BLEND_START_0: cfg_in.blend[0] = csr_write_data;
            CSR_BLEND_START_1: cfg_in.blend[1] = csr_write_data;
            CSR_BLEND_START_2: cfg_in.blend[2] = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{count: CountBits'(1), far: '0, blend: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sdsel_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_depth  (req_view_depth),
      .cfg       (cfg_ff),
      .out_valid (chain_valid[0]),
      .out_side  (chain_side[0]),
      .out_div   (chain_div[0])
   );

   for (genvar g = 0; g < FracBits; g++) begin : g_cell
      sdsel_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_side   (chain_side[g]),
         .in_div    (chain_div[g]),
         .out_valid (chain_valid[g+1]),
         .out_side  (chain_side[g+1]),
         .out_div   (chain_div[g+1])
      );
   end

   assign rsp_strobe            = chain_valid[FracBits];
   assign rsp_primary_cascade   = chain_side[FracBits].primary;
   assign rsp_secondary_cascade = chain_side[FracBits].secondary;
   assign rsp_beyond_range      = chain_side[FracBits].beyond;
   assign rsp_secondary_weight  = chain_side[FracBits].sat ?
                                  WeightBits'(1) << FracBits :
                                  {1'b0, chain_div[FracBits].quo};

`ifndef SYNTHESIS
   a_beyond_no_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_beyond_range |-> rsp_secondary_weight == '0)
      else $error("beyond-range transaction carries a blend weight");

   a_secondary_next: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_secondary_cascade == rsp_primary_cascade) ||
                     (rsp_secondary_cascade == rsp_primary_cascade + IdxBits'(1)))
      else $error("secondary cascade is neither primary nor the next one");

   a_weight_needs_blend: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_secondary_weight != '0 |->
         rsp_secondary_cascade != rsp_primary_cascade)
      else $error("nonzero weight without a blend cascade");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_secondary_weight <= (WeightBits'(1) << FracBits))
      else $error("blend weight above one");

   a_no_accept_in_reset: assert property (@(posedge clock)
      reset |=> !chain_valid[0])
      else $error("select stage valid right after reset");
`endif

endmodule

// ----- sv/sdsel_select.sv -----
// Cascade match, blend decision and divider operand setup (two stages).
module sdsel_select import sdsel_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic signed [DepthBits-1:0] in_depth,
   input  sdsel_cfg_type               cfg,
   output logic                        out_valid,
   output sdsel_side_type              out_side,
   output sdsel_div_type               out_div
);

   logic [CountBits-1:0]   n;
   logic [MaxCascades-1:0] match;
   logic                   found;
   logic [IdxBits-1:0]     idx;
   logic [IdxBits-1:0]     last;
   logic                   neg;
   logic [RegBits-1:0]     dmag;

   logic                 a_valid_ff, a_valid_in;
   logic [RegBits-1:0]   a_depth_ff, a_depth_in;
   logic [IdxBits-1:0]   a_idx_ff, a_idx_in;
   logic                 a_beyond_ff, a_beyond_in;
   logic                 a_cand_ff, a_cand_in;

   logic [RegBits-1:0]   far_sel;
   logic [RegBits-1:0]   bs_sel;
   logic                 blend;
   logic [RegBits:0]     den_wide;
   logic [RegBits-1:0]   den;
   logic [RegBits-1:0]   num;

   logic                 b_valid_ff, b_valid_in;
   sdsel_side_type       b_side_ff, b_side_in;
   sdsel_div_type        b_div_ff, b_div_in;

   always_comb begin
      n = (cfg.count > CountBits'(MaxCascades)) ? CountBits'(MaxCascades) : cfg.count;
      neg = in_depth[DepthBits-1];
      dmag = in_depth[RegBits-1:0];
      for (int i = 0; i < MaxCascades; i++) begin
         match[i] = (CountBits'(i) < n) && (dmag <= cfg.far[i]);
      end
      found = 1'b0;
      idx = '0;
      for (int i = MaxCascades - 1; i >= 0; i--) begin
         if (match[i]) begin
            found = 1'b1;
            idx = IdxBits'(i);
         end
      end
      last = (n == '0) ? '0 : IdxBits'(n - CountBits'(1));
   end

   always_comb begin
      a_valid_in  = in_valid;
      a_depth_in  = dmag;
      a_beyond_in = neg || (n == '0) || !found;
      a_cand_in   = 1'b0;
      if (neg || (n == '0)) begin
         a_idx_in = '0;
      end else if (found) begin
         a_idx_in  = idx;
         a_cand_in = (CountBits'(idx) + CountBits'(1)) < n;
      end else begin
         a_idx_in = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      a_depth_ff  <= a_depth_in;
      a_idx_ff    <= a_idx_in;
      a_beyond_ff <= a_beyond_in;
      a_cand_ff   <= a_cand_in;
   end

   always_comb begin
      far_sel = '0;
      bs_sel  = '0;
      for (int i = 0; i < MaxCascades; i++) begin
         if (a_idx_ff == IdxBits'(i)) begin
            far_sel = cfg.far[i];
         end
      end
      for (int i = 0; i < MaxCascades - 1; i++) begin
         if (a_idx_ff == IdxBits'(i)) begin
            bs_sel = cfg.blend[i];
         end
      end
      blend    = a_cand_ff && (a_depth_ff > bs_sel);
      num      = a_depth_ff - bs_sel;
      den_wide = {1'b0, far_sel} - {1'b0, bs_sel};
      den      = (den_wide[RegBits] || (den_wide == '0)) ? RegBits'(1) : den_wide[RegBits-1:0];

      b_valid_in          = a_valid_ff;
      b_side_in.primary   = a_idx_ff;
      b_side_in.beyond    = a_beyond_ff;
      b_side_in.secondary = a_idx_ff;
      b_side_in.sat       = 1'b0;
      b_div_in.rem        = '0;
      b_div_in.den        = RegBits'(1);
      b_div_in.quo        = '0;
      if (blend) begin
         b_side_in.secondary = a_idx_ff + IdxBits'(1);
         b_div_in.den        = den;
         if (num >= den) begin
            b_side_in.sat = 1'b1;
         end else begin
            b_div_in.rem = num;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
      b_side_ff <= b_side_in;
      b_div_ff  <= b_div_in;
   end

   assign out_valid = b_valid_ff;
   assign out_side  = b_side_ff;
   assign out_div   = b_div_ff;

endmodule

// ----- sv/sdsel_div_cell.sv -----
// One restoring-division cell: produces one quotient bit per transaction.
module sdsel_div_cell import sdsel_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  sdsel_side_type in_side,
   input  sdsel_div_type  in_div,
   output logic           out_valid,
   output sdsel_side_type out_side,
   output sdsel_div_type  out_div
);

   logic [RegBits:0]   shifted;
   logic [RegBits:0]   diff;
   logic               ge;

   logic               valid_ff, valid_in;
   sdsel_side_type     side_ff, side_in;
   sdsel_div_type      div_ff, div_in;

   always_comb begin
      shifted     = {in_div.rem, 1'b0};
      diff        = shifted - {1'b0, in_div.den};
      ge          = shifted >= {1'b0, in_div.den};
      valid_in    = in_valid;
      side_in     = in_side;
      div_in.den  = in_div.den;
      div_in.rem  = ge ? diff[RegBits-1:0] : shifted[RegBits-1:0];
      div_in.quo  = {in_div.quo[FracBits-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      side_ff <= side_in;
      div_ff  <= div_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_div   = div_ff;

endmodule
